// ----- hw/rtl/pcm_playout_ring_buffer_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the PCM playout ring buffer core.
// Each macro expands to a named concurrent assertion, or to nothing.
// ----------------------------------------------------------------------------
`ifndef PCM_PLAYOUT_RING_BUFFER_CORE_DEFINES_SVH
`define PCM_PLAYOUT_RING_BUFFER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PPRB_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PPRB_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PPRB_ASSERT_IMPL(label, clk, rst, prop, msg)
`define PPRB_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ----- hw/rtl/pprb_pkg.sv -----
// ----------------------------------------------------------------------------
// PCM playout ring buffer package
// Shared widths, operation and status codes, and controller/datapath types.
// ----------------------------------------------------------------------------
package pprb_pkg;

   localparam int RingDepth = 65536;
   localparam int PtrW = $clog2(RingDepth);
   localparam int FillW = PtrW + 1;
   localparam int MaxFrameSamples = 960;

   typedef enum logic [2:0] {
      OP_START = 3'd0, OP_WRITE_OPEN = 3'd1, OP_WRITE_BYTE = 3'd2, OP_CLEAR = 3'd3,
      OP_QUIESCE = 3'd4, OP_STOP = 3'd5, OP_RENDER_BEGIN = 3'd6, OP_RENDER_SAMPLE = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_ALREADY = 3'd1, ST_STALE = 3'd2, ST_BAD_SIZE = 3'd3,
      ST_NO_ROOM = 3'd4, ST_NOT_OPEN = 3'd5, ST_MUTED = 3'd6, ST_UNDERRUN = 3'd7
   } status_type;

   localparam logic [0:0] CSR_STEREO = 1'b0;
   localparam logic [0:0] CSR_GEN = 1'b1;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] generation;
      logic [31:0] epoch;
      logic [17:0] byte_count;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] sample;
      logic [16:0] frames_held;
      logic [31:0] frames_in;
      logic [31:0] frames_dropped;
      logic [31:0] frames_played;
      logic [31:0] render_count;
      logic [31:0] underrun_count;
      logic [31:0] current_epoch;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic execute;
      logic finish;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic busy;
   } stat_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

// ----- hw/rtl/pprb_stream_if.sv -----
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one word of a given type per handshake.
// ----------------------------------------------------------------------------
interface pprb_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/pprb_ctrl.sv -----
// ----------------------------------------------------------------------------
// PCM playout ring buffer controller
// Sequences each word through its states: accept, execute, result.
// ----------------------------------------------------------------------------
module pprb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pprb_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_type;
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EXEC;
         S_EXEC: state_in = S_OUT;
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign cmd.execute = (state_ff == S_EXEC);
   assign cmd.finish = (state_ff == S_OUT) && rsp_ready;

endmodule

// ----- hw/rtl/pprb_datapath.sv -----
// ----------------------------------------------------------------------------
// PCM playout ring buffer datapath
// Session state, ring memory, counters and the result register.
// ----------------------------------------------------------------------------
module pprb_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  pprb_pkg::req_type req,
   input  pprb_pkg::cmd_type cmd,
   input  logic              cfg_stereo,
   input  logic [31:0]       cfg_gen,
   output pprb_pkg::rsp_type rsp,
   output pprb_pkg::stat_type stat
);

   localparam int PW = pprb_pkg::PtrW;
   localparam int FW = pprb_pkg::FillW;

   logic [15:0] ring [pprb_pkg::RingDepth];
   logic [15:0] rd_data_ff;

   pprb_pkg::req_type req_ff;
   logic [PW-1:0] rp_ff, rp_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic act_ff, act_in, acc_ff, acc_in, ster_ff, ster_in;
   logic [31:0] gen_ff, gen_in, ep_ff, ep_in;
   logic [17:0] pend_ff, pend_in;
   logic held_v_ff, held_v_in;
   logic [7:0] held_ff, held_in;
   logic [9:0] frem_ff, frem_in, ftake_ff, ftake_in;
   logic [31:0] c_acc_ff, c_acc_in, c_dis_ff, c_dis_in, c_con_ff, c_con_in;
   logic [31:0] c_ren_ff, c_ren_in, c_und_ff, c_und_in;
   pprb_pkg::rsp_type rsp_ff, rsp_in;
   logic busy_ff;

   logic wr_en;
   logic [PW-1:0] wr_addr;
   logic [15:0] wr_data;

   always_ff @(posedge clock) begin
      if (load) req_ff <= req;
      rd_data_ff <= ring[rp_ff];
      if (wr_en && cmd.execute) ring[wr_addr] <= wr_data;
   end

   always_comb begin
      logic gen_ok, in_chunk;
      logic [17:0] limit, rem, pend_dec;
      logic [FW-1:0] total_f, take_f;
      logic [9:0] total;
      logic [FW-1:0] drop_frames;
      logic [FW:0] room;
      logic drop;
      pprb_pkg::status_type st;
      logic [15:0] smp;
      rp_in = rp_ff; fill_in = fill_ff; act_in = act_ff; acc_in = acc_ff;
      ster_in = ster_ff; gen_in = gen_ff; ep_in = ep_ff; pend_in = pend_ff;
      held_v_in = held_v_ff; held_in = held_ff; frem_in = frem_ff; ftake_in = ftake_ff;
      c_acc_in = c_acc_ff; c_dis_in = c_dis_ff; c_con_in = c_con_ff;
      c_ren_in = c_ren_ff; c_und_in = c_und_ff;
      wr_en = 1'b0;
      wr_addr = rp_ff + fill_ff[PW-1:0];
      wr_data = {req_ff.data_byte, held_ff};
      st = pprb_pkg::ST_OK;
      smp = 16'd0;
      drop = 1'b0;
      gen_ok = (req_ff.generation != 32'd0) && act_ff && (req_ff.generation == gen_ff);
      limit = ster_ff ? 18'd192000 : 18'd48000;
      total = ster_ff ? 10'd960 : 10'd240;
      if (total > 10'(pprb_pkg::MaxFrameSamples)) total = 10'(pprb_pkg::MaxFrameSamples);
      total_f = FW'(total);
      take_f = (fill_ff < total_f) ? fill_ff : total_f;
      drop_frames = ster_ff ? (fill_ff >> 1) : fill_ff;
      room = (FW+1)'(pprb_pkg::RingDepth) - (FW+1)'(fill_ff);
      rem = ster_ff ? {16'd0, req_ff.byte_count[1:0]} : {17'd0, req_ff.byte_count[0]};
      pend_dec = pend_ff - 18'd1;
      in_chunk = 1'b0;
      case (pprb_pkg::op_type'(req_ff.operation))
         pprb_pkg::OP_START: begin
            if (act_ff) begin
               st = pprb_pkg::ST_ALREADY;
            end else begin
               ster_in = cfg_stereo;
               gen_in = (cfg_gen != 32'd0) ? cfg_gen : 32'd1;
               act_in = 1'b1; acc_in = 1'b1; ep_in = 32'd0;
               c_acc_in = 32'd0; c_dis_in = 32'd0; c_con_in = 32'd0;
               c_ren_in = 32'd0; c_und_in = 32'd0;
               fill_in = '0; rp_in = '0; pend_in = '0; held_v_in = 1'b0; held_in = '0;
               frem_in = '0; ftake_in = '0;
            end
         end
         pprb_pkg::OP_WRITE_OPEN: begin
            pend_in = '0; held_v_in = 1'b0; held_in = '0;
            if (!acc_ff || !gen_ok || req_ff.epoch != ep_ff) st = pprb_pkg::ST_STALE;
            else if (req_ff.byte_count == 18'd0 || rem != 18'd0 || req_ff.byte_count > limit)
               st = pprb_pkg::ST_BAD_SIZE;
            else if ((FW+1)'(req_ff.byte_count[17:1]) > room) st = pprb_pkg::ST_NO_ROOM;
            else pend_in = req_ff.byte_count;
         end
         pprb_pkg::OP_WRITE_BYTE: begin
            if (pend_ff == 18'd0) begin
               st = pprb_pkg::ST_NOT_OPEN;
            end else begin
               in_chunk = 1'b1;
               if (!held_v_ff) begin
                  held_in = req_ff.data_byte; held_v_in = 1'b1;
               end else begin
                  wr_en = 1'b1; held_v_in = 1'b0; held_in = '0;
                  fill_in = fill_ff + FW'(1);
               end
               pend_in = pend_dec;
               if ((ster_ff ? pend_dec[1:0] : {1'b0, pend_dec[0]}) == 2'd0)
                  c_acc_in = pprb_pkg::sat_add(c_acc_ff, 32'd1);
            end
         end
         pprb_pkg::OP_CLEAR: begin
            if (!acc_ff || !gen_ok || req_ff.epoch <= ep_ff) st = pprb_pkg::ST_STALE;
            else begin drop = 1'b1; ep_in = req_ff.epoch; end
         end
         pprb_pkg::OP_QUIESCE: begin
            if (!gen_ok) st = pprb_pkg::ST_STALE;
            else begin acc_in = 1'b0; drop = 1'b1; end
         end
         pprb_pkg::OP_STOP: begin
            drop = 1'b1; act_in = 1'b0; gen_in = 32'd0; acc_in = 1'b0;
         end
         pprb_pkg::OP_RENDER_BEGIN: begin
            if (!act_ff) begin
               st = pprb_pkg::ST_MUTED; frem_in = '0; ftake_in = '0;
            end else begin
               ftake_in = take_f[9:0];
               frem_in = total;
               c_con_in = pprb_pkg::sat_add(c_con_ff,
                  32'(ster_ff ? (take_f >> 1) : take_f));
               c_ren_in = pprb_pkg::sat_add(c_ren_ff, 32'd1);
               if (take_f < total_f) begin
                  c_und_in = pprb_pkg::sat_add(c_und_ff, 32'd1);
                  st = pprb_pkg::ST_UNDERRUN;
               end
            end
         end
         default: begin
            if (frem_ff == 10'd0) begin
               st = act_ff ? pprb_pkg::ST_NOT_OPEN : pprb_pkg::ST_MUTED;
            end else begin
               frem_in = frem_ff - 10'd1;
               if (ftake_ff != 10'd0 && fill_ff != '0) begin
                  smp = rd_data_ff;
                  rp_in = rp_ff + PW'(1);
                  fill_in = fill_ff - FW'(1);
                  ftake_in = ftake_ff - 10'd1;
               end else begin
                  ftake_in = '0; st = pprb_pkg::ST_UNDERRUN;
               end
            end
         end
      endcase
      if (drop) begin
         c_dis_in = pprb_pkg::sat_add(c_dis_ff, 32'(drop_frames));
         fill_in = '0; rp_in = '0; pend_in = '0; held_v_in = 1'b0; held_in = '0;
         frem_in = '0; ftake_in = '0;
      end
      if (!in_chunk) wr_en = 1'b0;
      rsp_in.status = st;
      rsp_in.sample = smp;
      rsp_in.frames_held = 17'(ster_in ? (fill_in >> 1) : fill_in);
      rsp_in.frames_in = c_acc_in;
      rsp_in.frames_dropped = c_dis_in;
      rsp_in.frames_played = c_con_in;
      rsp_in.render_count = c_ren_in;
      rsp_in.underrun_count = c_und_in;
      rsp_in.current_epoch = ep_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff <= '0; fill_ff <= '0; act_ff <= 1'b0; acc_ff <= 1'b0; ster_ff <= 1'b0;
         gen_ff <= '0; ep_ff <= '0; pend_ff <= '0; held_v_ff <= 1'b0; held_ff <= '0;
         frem_ff <= '0; ftake_ff <= '0;
         c_acc_ff <= '0; c_dis_ff <= '0; c_con_ff <= '0; c_ren_ff <= '0; c_und_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         if (load) busy_ff <= 1'b1;
         else if (cmd.finish) busy_ff <= 1'b0;
         if (cmd.execute) begin
            rp_ff <= rp_in; fill_ff <= fill_in; act_ff <= act_in; acc_ff <= acc_in;
            ster_ff <= ster_in; gen_ff <= gen_in; ep_ff <= ep_in; pend_ff <= pend_in;
            held_v_ff <= held_v_in; held_ff <= held_in; frem_ff <= frem_in;
            ftake_ff <= ftake_in; c_acc_ff <= c_acc_in; c_dis_ff <= c_dis_in;
            c_con_ff <= c_con_in; c_ren_ff <= c_ren_in; c_und_ff <= c_und_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) rsp_ff <= rsp_in;
   end

   assign rsp = rsp_ff;
   assign stat.busy = busy_ff;

endmodule

// ----- hw/rtl/pcm_playout_ring_buffer_core.sv -----
// Order: a word is captured on accept, executed in the execute state, and its result is
// held valid in the result state until rsp_ready; a new word is accepted only when idle,
// so words do not overlap. The ring read is registered ahead of use.
// Reset: synchronous, active high; clears session state, pointers and counters.
// The ring memory is not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
// PCM playout ring buffer core
// Top level joining the controller, the datapath and the register port.
// ----------------------------------------------------------------------------
`include "pcm_playout_ring_buffer_core_defines.svh"
module pcm_playout_ring_buffer_core (
   input  logic        clock,
   input  logic        reset,
   pprb_stream_if.sink   req,
   pprb_stream_if.source rsp,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic stereo_ff;
   logic [31:0] gen_id_ff;
   pprb_pkg::cmd_type cmd;
   pprb_pkg::stat_type stat;
   logic load;

   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff <= 1'b0;
         gen_id_ff <= 32'd1;
      end else if (csr_write) begin
         case (csr_index)
            pprb_pkg::CSR_STEREO: stereo_ff <= csr_data[0];
            pprb_pkg::CSR_GEN: gen_id_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign load = req.valid && req.ready;

   pprb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .cmd(cmd)
   );

   pprb_datapath u_dp (
      .clock(clock), .reset(reset), .load(load), .req(req.payload), .cmd(cmd),
      .cfg_stereo(stereo_ff), .cfg_gen(gen_id_ff), .rsp(rsp.payload), .stat(stat)
   );

   `PPRB_ASSERT_NEVER(a_no_accept_busy, clock, reset, load && stat.busy && !cmd.finish, "word accepted while busy")
   `PPRB_ASSERT_IMPL(a_exec_after_load, clock, reset, load |=> cmd.execute, "no execute after accept")
   `PPRB_ASSERT_IMPL(a_busy_on_valid, clock, reset, rsp.valid |-> stat.busy, "result without word")

endmodule

// ----- test/pcm_playout_ring_buffer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM playout ring buffer core testbench
// Drives start, chunk writes, renders, clears, quiesces and stops through the
// request stream and checks every response word against a cycle-free model of
// the session, ring and counters kept inside this bench.
// ----------------------------------------------------------------------------
module pcm_playout_ring_buffer_core_tb;

   localparam int CycleLimit = 600000;

   typedef struct {
      pprb_pkg::op_type     op;
      logic [31:0]          generation;
      logic [31:0]          epoch;
      logic [17:0]          byte_count;
      logic [7:0]           data_byte;
      bit                   fixed;
      pprb_pkg::status_type status;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [0:0] csr_index = pprb_pkg::CSR_STEREO;
   logic [31:0] csr_data = '0;

   pprb_stream_if #(.payload_type(pprb_pkg::req_type)) req ();
   pprb_stream_if #(.payload_type(pprb_pkg::rsp_type)) rsp ();

   pcm_playout_ring_buffer_core dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // Model state.
   logic [15:0] ring_words [0:pprb_pkg::RingDepth-1];
   int unsigned rd_ptr, fill, bytes_left, frame_left, frame_take;
   int unsigned live_gen, epoch_now;
   logic [31:0] stats [0:4];
   bit session_on, writes_on, stereo_on, held_ok;
   logic [7:0] held_lo;
   bit cfg_stereo = 1'b0;
   logic [31:0] cfg_gen = 32'd1;

   pprb_pkg::rsp_type expected_words [$];
   int unsigned words_checked, errors, cycles, starts_seen, renders_seen, pops_seen;
   bit no_idle, hold_rsp;

   function automatic logic [31:0] sat_inc(input logic [31:0] a, input int unsigned b);
      logic [32:0] s;
      s = {1'b0, a} + 33'(b);
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic int unsigned chans();
      return stereo_on ? 2 : 1;
   endfunction

   function automatic void flush_ring();
      stats[1] = sat_inc(stats[1], fill / chans());
      fill = 0; rd_ptr = 0; bytes_left = 0; held_ok = 0; held_lo = '0;
      frame_left = 0; frame_take = 0;
   endfunction

   function automatic pprb_pkg::rsp_type playout_next(input pprb_pkg::req_type w);
      pprb_pkg::rsp_type r;
      pprb_pkg::status_type st;
      logic [15:0] smp;
      bit gen_ok;
      int unsigned fb, limit, total;
      st = pprb_pkg::ST_OK;
      smp = '0;
      gen_ok = w.generation != 0 && session_on && w.generation == live_gen;
      case (pprb_pkg::op_type'(w.operation))
         pprb_pkg::OP_START: begin
            if (session_on) begin
               st = pprb_pkg::ST_ALREADY;
            end else begin
               stereo_on = cfg_stereo;
               live_gen = (cfg_gen != 0) ? cfg_gen : 1;
               session_on = 1; writes_on = 1; epoch_now = 0;
               for (int i = 0; i < 5; i++) stats[i] = '0;
               fill = 0; rd_ptr = 0; bytes_left = 0; held_ok = 0; held_lo = '0;
               frame_left = 0; frame_take = 0;
               starts_seen++;
            end
         end
         pprb_pkg::OP_WRITE_OPEN: begin
            fb = 2 * chans();
            limit = (stereo_on ? 48000 : 24000) * fb;
            bytes_left = 0; held_ok = 0; held_lo = '0;
            if (!writes_on || !gen_ok || w.epoch != epoch_now) st = pprb_pkg::ST_STALE;
            else if (w.byte_count == 0 || (w.byte_count % fb) != 0 || w.byte_count > limit)
               st = pprb_pkg::ST_BAD_SIZE;
            else if (w.byte_count / 2 > pprb_pkg::RingDepth - fill) st = pprb_pkg::ST_NO_ROOM;
            else bytes_left = w.byte_count;
         end
         pprb_pkg::OP_WRITE_BYTE: begin
            if (bytes_left == 0) begin
               st = pprb_pkg::ST_NOT_OPEN;
            end else begin
               if (!held_ok) begin
                  held_lo = w.data_byte; held_ok = 1;
               end else begin
                  ring_words[(rd_ptr + fill) % pprb_pkg::RingDepth] = {w.data_byte, held_lo};
                  held_ok = 0; held_lo = '0; fill++;
               end
               bytes_left--;
               if (bytes_left % (2 * chans()) == 0) stats[0] = sat_inc(stats[0], 1);
            end
         end
         pprb_pkg::OP_CLEAR: begin
            if (!writes_on || !gen_ok || w.epoch <= epoch_now) begin
               st = pprb_pkg::ST_STALE;
            end else begin
               flush_ring();
               epoch_now = w.epoch;
            end
         end
         pprb_pkg::OP_QUIESCE: begin
            if (!gen_ok) st = pprb_pkg::ST_STALE;
            else begin
               writes_on = 0;
               flush_ring();
            end
         end
         pprb_pkg::OP_STOP: begin
            flush_ring();
            session_on = 0; live_gen = 0; writes_on = 0;
         end
         pprb_pkg::OP_RENDER_BEGIN: begin
            total = (stereo_on ? 480 : 240) * chans();
            if (!session_on) begin
               st = pprb_pkg::ST_MUTED; frame_left = 0; frame_take = 0;
            end else begin
               if (total > pprb_pkg::MaxFrameSamples) total = pprb_pkg::MaxFrameSamples;
               frame_take = fill < total ? fill : total;
               frame_left = total;
               stats[2] = sat_inc(stats[2], frame_take / chans());
               stats[3] = sat_inc(stats[3], 1);
               if (frame_take < total) begin
                  stats[4] = sat_inc(stats[4], 1);
                  st = pprb_pkg::ST_UNDERRUN;
               end
               renders_seen++;
            end
         end
         default: begin
            if (frame_left == 0) begin
               st = session_on ? pprb_pkg::ST_NOT_OPEN : pprb_pkg::ST_MUTED;
            end else begin
               frame_left--;
               if (frame_take > 0 && fill > 0) begin
                  smp = ring_words[rd_ptr];
                  rd_ptr = (rd_ptr + 1) % pprb_pkg::RingDepth;
                  fill--; frame_take--; pops_seen++;
               end else begin
                  frame_take = 0;
                  st = pprb_pkg::ST_UNDERRUN;
               end
            end
         end
      endcase
      r.status = st;
      r.sample = smp;
      r.frames_held = 17'(fill / chans());
      r.frames_in = stats[0];
      r.frames_dropped = stats[1];
      r.frames_played = stats[2];
      r.render_count = stats[3];
      r.underrun_count = stats[4];
      r.current_epoch = epoch_now;
      return r;
   endfunction

   task automatic send_word(input pprb_pkg::req_type w, input bit fixed,
                            input pprb_pkg::status_type st);
      pprb_pkg::rsp_type e;
      if (!no_idle && $urandom_range(0, 99) < 15) begin
         req.valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req.valid = 1'b1;
      req.payload = w;
      do @(posedge clock); while (!req.ready);
      e = playout_next(w);
      if (fixed) e.status = st;
      expected_words.push_back(e);
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   task automatic send_op(input pprb_pkg::op_type op, input logic [31:0] g,
                          input logic [31:0] ep, input logic [17:0] bc, input logic [7:0] db);
      pprb_pkg::req_type w;
      w.operation = op; w.generation = g; w.epoch = ep; w.byte_count = bc; w.data_byte = db;
      send_word(w, 1'b0, pprb_pkg::ST_OK);
   endtask

   task automatic drain();
      while (expected_words.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
      drain();
      csr_write = 1'b1; csr_index = idx; csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
      if (idx == pprb_pkg::CSR_STEREO) cfg_stereo = value[0];
      else cfg_gen = value;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      pprb_pkg::rsp_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word expected none actual %p", $time, rsp.payload);
            errors++;
         end else begin
            e = expected_words.pop_front();
            check_field("status", e.status, rsp.payload.status);
            check_field("sample", e.sample, rsp.payload.sample);
            check_field("frames_held", e.frames_held, rsp.payload.frames_held);
            check_field("frames_in", e.frames_in, rsp.payload.frames_in);
            check_field("frames_dropped", e.frames_dropped, rsp.payload.frames_dropped);
            check_field("frames_played", e.frames_played, rsp.payload.frames_played);
            check_field("render_count", e.render_count, rsp.payload.render_count);
            check_field("underrun_count", e.underrun_count, rsp.payload.underrun_count);
            check_field("current_epoch", e.current_epoch, rsp.payload.current_epoch);
            words_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp.ready = 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp.ready = no_idle || $urandom_range(0, 99) >= 15;
         end
      end
   end

   // One random burst of activity; mostly well-formed sequences.
   task automatic random_burst(inout int unsigned sent);
      int unsigned pick, k, n, fb;
      pick = $urandom_range(0, 99);
      fb = 2 * chans();
      if (!session_on && pick < 70) begin
         send_op(pprb_pkg::OP_START, $urandom, $urandom, $urandom_range(0, 262143), $urandom);
         sent++;
      end else if (pick < 12) begin
         send_op(pprb_pkg::op_type'($urandom_range(0, 7)), $urandom, $urandom,
                 $urandom_range(0, 262143), $urandom);
         sent++;
      end else if (pick < 50) begin
         if ($urandom_range(0, 19) == 0) k = $urandom_range(0, 50000) * fb;
         else k = $urandom_range(1, 16) * fb;
         if ($urandom_range(0, 15) == 0) k = k + $urandom_range(1, 3);
         send_op(pprb_pkg::OP_WRITE_OPEN, live_gen, epoch_now, 18'(k), $urandom);
         sent++;
         if (bytes_left != 0) begin
            n = bytes_left;
            if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
            for (int i = 0; i < n; i++) begin
               send_op(pprb_pkg::OP_WRITE_BYTE, $urandom, $urandom,
                       $urandom_range(0, 262143), $urandom);
               sent++;
            end
         end
      end else if (pick < 88) begin
         send_op(pprb_pkg::OP_RENDER_BEGIN, $urandom, $urandom,
                 $urandom_range(0, 262143), $urandom);
         sent++;
         n = ($urandom_range(0, 29) == 0) ? frame_left + 2 : $urandom_range(0, 24);
         for (int i = 0; i < n; i++) begin
            send_op(pprb_pkg::OP_RENDER_SAMPLE, $urandom, $urandom,
                    $urandom_range(0, 262143), $urandom);
            sent++;
         end
      end else if (pick < 94) begin
         send_op(pprb_pkg::OP_CLEAR, live_gen, epoch_now + $urandom_range(0, 3),
                 $urandom_range(0, 262143), $urandom);
         sent++;
      end else if (pick < 97) begin
         send_op(pprb_pkg::OP_QUIESCE, live_gen, $urandom, $urandom_range(0, 262143), $urandom);
         sent++;
      end else begin
         send_op(pprb_pkg::OP_STOP, $urandom, $urandom, $urandom_range(0, 262143), $urandom);
         sent++;
      end
   endtask

   row_type rows [] = '{
      '{pprb_pkg::OP_RENDER_BEGIN,  32'd0, 32'd0, 18'd0, 8'h00, 1, pprb_pkg::ST_MUTED},
      '{pprb_pkg::OP_RENDER_SAMPLE, 32'd0, 32'd0, 18'd0, 8'h00, 1, pprb_pkg::ST_MUTED},
      '{pprb_pkg::OP_WRITE_BYTE,    32'd0, 32'd0, 18'd0, 8'hFF, 1, pprb_pkg::ST_NOT_OPEN},
      '{pprb_pkg::OP_WRITE_OPEN,    32'd1, 32'd0, 18'd4, 8'h00, 1, pprb_pkg::ST_STALE},
      '{pprb_pkg::OP_START,         32'd0, 32'd0, 18'd0, 8'h00, 1, pprb_pkg::ST_OK},
      '{pprb_pkg::OP_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 18'h3FFFF, 8'hFF, 1,
        pprb_pkg::ST_ALREADY},
      '{pprb_pkg::OP_WRITE_OPEN,    32'd0, 32'd0, 18'd4, 8'h00, 1, pprb_pkg::ST_STALE},
      '{pprb_pkg::OP_WRITE_OPEN,    32'd1, 32'd5, 18'd4, 8'h00, 1, pprb_pkg::ST_STALE},
      '{pprb_pkg::OP_WRITE_OPEN,    32'd1, 32'd0, 18'd0, 8'h00, 1, pprb_pkg::ST_BAD_SIZE},
      '{pprb_pkg::OP_WRITE_OPEN,    32'd1, 32'd0, 18'd3, 8'h00, 1, pprb_pkg::ST_BAD_SIZE},
      '{pprb_pkg::OP_WRITE_OPEN,    32'd1, 32'd0, 18'd48002, 8'h00, 1, pprb_pkg::ST_BAD_SIZE},
      '{pprb_pkg::OP_WRITE_OPEN,    32'd1, 32'd0, 18'h3FFFE, 8'h00, 1, pprb_pkg::ST_BAD_SIZE},
      '{pprb_pkg::OP_WRITE_OPEN,    32'd1, 32'd0, 18'd4, 8'h00, 1, pprb_pkg::ST_OK},
      '{pprb_pkg::OP_WRITE_BYTE,    32'd0, 32'd0, 18'd0, 8'h00, 0, pprb_pkg::ST_OK},
      '{pprb_pkg::OP_WRITE_BYTE,    32'd0, 32'd0, 18'd0, 8'h80, 0, pprb_pkg::ST_OK},
      '{pprb_pkg::OP_WRITE_BYTE,    32'd0, 32'd0, 18'd0, 8'hFF, 0, pprb_pkg::ST_OK},
      '{pprb_pkg::OP_WRITE_BYTE,    32'd0, 32'd0, 18'd0, 8'h7F, 0, pprb_pkg::ST_OK},
      '{pprb_pkg::OP_RENDER_BEGIN,  32'd0, 32'd0, 18'd0, 8'h00, 1, pprb_pkg::ST_UNDERRUN},
      '{pprb_pkg::OP_RENDER_SAMPLE, 32'd0, 32'd0, 18'd0, 8'h00, 0, pprb_pkg::ST_OK},
      '{pprb_pkg::OP_RENDER_SAMPLE, 32'd0, 32'd0, 18'd0, 8'h00, 0, pprb_pkg::ST_OK},
      '{pprb_pkg::OP_RENDER_SAMPLE, 32'd0, 32'd0, 18'd0, 8'h00, 1, pprb_pkg::ST_UNDERRUN},
      '{pprb_pkg::OP_CLEAR,         32'd1, 32'd0, 18'd0, 8'h00, 1, pprb_pkg::ST_STALE},
      '{pprb_pkg::OP_CLEAR,         32'd1, 32'hFFFF_FFFF, 18'd0, 8'h00, 1, pprb_pkg::ST_OK},
      '{pprb_pkg::OP_QUIESCE,       32'd2, 32'd0, 18'd0, 8'h00, 1, pprb_pkg::ST_STALE},
      '{pprb_pkg::OP_QUIESCE,       32'd1, 32'd0, 18'd0, 8'h00, 1, pprb_pkg::ST_OK},
      '{pprb_pkg::OP_STOP,          32'd0, 32'd0, 18'd0, 8'h00, 1, pprb_pkg::ST_OK}
   };

   logic [31:0] phase_gen [5] = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'h8000_0001, 32'h7FFF_FFFE};
   bit phase_stereo [5] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

   initial begin
      pprb_pkg::req_type w;
      int unsigned sent;
      req.valid = 1'b0;
      req.payload = '0;
      rd_ptr = 0; fill = 0; bytes_left = 0; frame_left = 0; frame_take = 0;
      live_gen = 0; epoch_now = 0; session_on = 0; writes_on = 0; stereo_on = 0;
      held_ok = 0; held_lo = '0;
      for (int i = 0; i < 5; i++) stats[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         w.operation = rows[i].op; w.generation = rows[i].generation;
         w.epoch = rows[i].epoch; w.byte_count = rows[i].byte_count;
         w.data_byte = rows[i].data_byte;
         send_word(w, rows[i].fixed, rows[i].status);
      end

      for (int p = 0; p < 5; p++) begin
         write_reg(pprb_pkg::CSR_STEREO, {31'd0, phase_stereo[p]});
         write_reg(pprb_pkg::CSR_GEN, (p == 3) ? $urandom : phase_gen[p]);
         no_idle = (p == 2);
         send_op(pprb_pkg::OP_STOP, '0, '0, '0, '0);
         send_op(pprb_pkg::OP_START, '0, '0, '0, '0);
         if (phase_stereo[p])
            send_op(pprb_pkg::OP_WRITE_OPEN, live_gen, epoch_now, 18'd131076, '0);
         sent = 0;
         while (sent < 400) begin
            if (p == 1 && sent > 100 && sent < 110) hold_rsp = 1'b1;
            random_burst(sent);
         end
      end

      drain();
      repeat (20) @(negedge clock);
      $display("Checked %0d response words: %0d starts, %0d renders, %0d samples popped.",
               words_checked, starts_seen, renders_seen, pops_seen);
      if (errors == 0 && expected_words.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
